>>> hdl/sorted_table_binary_search_top_assert.svh
// Assertion macros for the sorted table search block.
// Used by the controller and datapath files; needs clk_i and rst_ni in scope.
`ifndef SORTED_TABLE_BINARY_SEARCH_TOP_ASSERT_SVH
`define SORTED_TABLE_BINARY_SEARCH_TOP_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define STBS_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

// Check that a condition implies another in the same cycle.
`define STBS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies another in the next cycle.
`define STBS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/stbs_pkg.sv
// Shared types and constants for the sorted table search block.
// Used by stbs_ctrl, stbs_dpath and the top level; depends on nothing.
package stbs_pkg;

  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned OPC_W       = 2;
  localparam int unsigned IDX_W       = 10;

  // Input word opcodes; the fourth code is ignored.
  typedef enum logic [OPC_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_SEARCH = 2'd2
  } op_e;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_CMP
  } state_e;

  // Datapath commands, one per cycle.
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_CLEAR,
    CMD_APPEND,
    CMD_START,
    CMD_READ,
    CMD_GO_LOW,
    CMD_GO_HIGH,
    CMD_DONE_FOUND,
    CMD_DONE_MISS
  } cmd_e;

  typedef struct packed {
    cmd_e op;
  } ctrl_cmd_t;

  typedef struct packed {
    logic bounds_open;  // low bound below exclusive high bound
    logic probe_eq;     // probed entry equals key
    logic probe_gt;     // probed entry greater than key
    logic out_free;     // output register can take a word this cycle
  } dp_status_t;

endpackage

>>> hdl/stbs_ctrl.sv
// Controller state machine for the sorted table search block.
// Depends on stbs_pkg and the assertion header; drives datapath commands.
`include "sorted_table_binary_search_top_assert.svh"

module stbs_ctrl (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [stbs_pkg::OPC_W-1:0]          in_opcode_i,
  input  stbs_pkg::dp_status_t                status_i,
  output stbs_pkg::ctrl_cmd_t                 cmd_o
);
  import stbs_pkg::*;

  state_e state_q, state_d;
  logic   accept;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (op_e'(in_opcode_i) == OP_SEARCH)) state_d = ST_PROBE;
      end
      ST_PROBE: begin
        if (status_i.bounds_open) state_d = ST_CMP;
        else if (status_i.out_free) state_d = ST_IDLE;
      end
      ST_CMP: begin
        if (!status_i.probe_eq) state_d = ST_PROBE;
        else if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Command outputs
  always_comb begin
    cmd_o.op = CMD_NONE;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (in_opcode_i)
            OP_CLEAR:  cmd_o.op = CMD_CLEAR;
            OP_APPEND: cmd_o.op = CMD_APPEND;
            OP_SEARCH: cmd_o.op = CMD_START;
            default:   cmd_o.op = CMD_NONE;
          endcase
        end
      end
      ST_PROBE: begin
        if (status_i.bounds_open) cmd_o.op = CMD_READ;
        else if (status_i.out_free) cmd_o.op = CMD_DONE_MISS;
      end
      ST_CMP: begin
        if (!status_i.probe_eq) begin
          cmd_o.op = status_i.probe_gt ? CMD_GO_HIGH : CMD_GO_LOW;
        end else if (status_i.out_free) begin
          cmd_o.op = CMD_DONE_FOUND;
        end
      end
      default: cmd_o.op = CMD_NONE;
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `STBS_ASSERT_IMP(a_done_needs_free,
    (cmd_o.op == CMD_DONE_FOUND) || (cmd_o.op == CMD_DONE_MISS), status_i.out_free,
    "result issued while output register busy")
  `STBS_ASSERT_IMP(a_read_needs_open, cmd_o.op == CMD_READ, status_i.bounds_open,
    "probe read issued with crossed bounds")
  `STBS_ASSERT_NEXT(a_start_to_probe, cmd_o.op == CMD_START, state_q == ST_PROBE,
    "search start did not enter probe")

endmodule

>>> hdl/stbs_dpath.sv
// Datapath for the sorted table search block: table memory, entry count,
// search bounds and the output register. Depends on stbs_pkg and the assertion header.
`include "sorted_table_binary_search_top_assert.svh"

module stbs_dpath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic signed [stbs_pkg::DATA_W-1:0]  in_value_i,
  input  stbs_pkg::ctrl_cmd_t                 cmd_i,
  output stbs_pkg::dp_status_t                status_o,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                out_found_o,
  output logic [stbs_pkg::IDX_W-1:0]          out_match_index_o
);
  import stbs_pkg::*;

  logic signed [DATA_W-1:0] mem_q [TABLE_DEPTH];
  logic signed [DATA_W-1:0] rdata_q;
  logic signed [DATA_W-1:0] key_q;
  logic [CNT_W-1:0]         count_q, count_d;
  logic [CNT_W-1:0]         lo_q, lo_d;
  logic [CNT_W-1:0]         hx_q, hx_d;  // exclusive high bound
  logic [CNT_W:0]           mid_sum;
  logic [ADDR_W-1:0]        mid;
  logic                     full;
  logic                     out_valid_q, out_valid_d;
  logic                     found_q;
  logic [IDX_W-1:0]         index_q;

  // Midpoint of the inclusive bounds, rounded down
  assign mid_sum = {1'b0, lo_q} + {1'b0, hx_q} - {{CNT_W{1'b0}}, 1'b1};
  assign mid     = mid_sum[ADDR_W:1];
  assign full    = (count_q == CNT_W'(TABLE_DEPTH));

  assign status_o.bounds_open = (lo_q < hx_q);
  assign status_o.probe_eq    = (rdata_q == key_q);
  assign status_o.probe_gt    = (rdata_q > key_q);
  assign status_o.out_free    = !out_valid_q || !out_stall_i;

  // Table memory: write on append, registered read on probe
  always_ff @(posedge clk_i) begin
    if ((cmd_i.op == CMD_APPEND) && !full) begin
      mem_q[count_q[ADDR_W-1:0]] <= in_value_i;
    end
    if (cmd_i.op == CMD_READ) begin
      rdata_q <= mem_q[mid];
    end
  end

  // Count and bounds next values
  always_comb begin
    count_d = count_q;
    lo_d    = lo_q;
    hx_d    = hx_q;
    case (cmd_i.op)
      CMD_CLEAR:  count_d = '0;
      CMD_APPEND: if (!full) count_d = count_q + CNT_W'(1);
      CMD_START: begin
        lo_d = '0;
        hx_d = count_q;
      end
      CMD_GO_LOW:  lo_d = {1'b0, mid} + CNT_W'(1);
      CMD_GO_HIGH: hx_d = {1'b0, mid};
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Hold key and bounds for the running search
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == CMD_START) key_q <= in_value_i;
    lo_q <= lo_d;
    hx_q <= hx_d;
  end

  // Output register: load on done, drop when taken
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if ((cmd_i.op == CMD_DONE_FOUND) || (cmd_i.op == CMD_DONE_MISS)) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == CMD_DONE_FOUND) begin
      found_q <= 1'b1;
      index_q <= IDX_W'(mid);
    end else if (cmd_i.op == CMD_DONE_MISS) begin
      found_q <= 1'b0;
      index_q <= '0;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_found_o       = found_q;
  assign out_match_index_o = index_q;

  `STBS_ASSERT(a_count_in_range, count_q <= CNT_W'(TABLE_DEPTH),
    "entry count beyond table depth")
  `STBS_ASSERT_IMP(a_miss_index_zero, out_valid_q && !found_q, index_q == '0,
    "miss word carries nonzero index")
  `STBS_ASSERT_NEXT(a_held_while_stalled, out_valid_q && out_stall_i, out_valid_q,
    "pending result dropped while stalled")

endmodule

>>> hdl/sorted_table_binary_search_top.sv
// Top level of the sorted table search block.
// Depends on stbs_pkg, stbs_ctrl and stbs_dpath.
//
// Input channel: opcode and value words. Clear empties the table, append
// writes value as the next entry (ignored when the table holds 1024
// entries), search looks up value. Clear and append
// give no output word; the unused opcode is dropped.
// Output channel: one word per search, found flag and match index
// (index 0 on a miss).
// Each halving probe of a search is one registered memory read followed by
// one compare and bound update, between a start step and a finish step.
// In_stall_o is high from the cycle after a search is taken until its result
// is loaded into the output register.
// The output register lets the next word in while a result waits; a search
// that finishes while the previous result is still stalled holds until the
// receiver takes it.
// Reset clears the entry count and the output valid; table contents are
// not cleared and are only read below the entry count.
module sorted_table_binary_search_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [stbs_pkg::OPC_W-1:0]          in_opcode_i,
  input  logic signed [stbs_pkg::DATA_W-1:0]  in_value_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                out_found_o,
  output logic [stbs_pkg::IDX_W-1:0]          out_match_index_o
);
  import stbs_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Sequence the search probes
  stbs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_opcode_i (in_opcode_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Table, bounds and result
  stbs_dpath u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_value_i        (in_value_i),
    .cmd_i             (cmd),
    .status_o          (status),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_found_o       (out_found_o),
    .out_match_index_o (out_match_index_o)
  );

endmodule

>>> bench/tb_sorted_table_binary_search_top.sv
`timescale 1ns / 1ps
// Testbench for sorted_table_binary_search_top: clear, append and search words in, found and
// match index words out, each search checked against a behavioral copy of the table.
// Depends on stbs_pkg and the RTL of the top level.
module tb_sorted_table_binary_search_top;
  import stbs_pkg::*;

  localparam logic [OPC_W-1:0] OP_UNUSED    = 2'd3;
  // words of the random part, the full-table fill included
  localparam int unsigned      RANDOM_WORDS = 500;
  localparam int unsigned      HOLD_CYCLES  = 400;
  localparam int unsigned      DRAIN_CYCLES = 40;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] index;
  } search_result_t;

  typedef struct packed {
    logic [OPC_W-1:0]  op;
    logic [DATA_W-1:0] value;
    logic              use_typed;
    search_result_t    result;
  } stim_row_t;

  // Directed words; a typed result is used only where it is obvious (empty table).
  localparam stim_row_t DIRECTED_ROWS [24] = '{
    '{OP_SEARCH, 32'h0000_0000, 1'b1, '{1'b0, 10'd0}},  // search right after reset
    '{OP_UNUSED, 32'hFFFF_FFFF, 1'b0, '{1'b0, 10'd0}},  // unused code, dropped
    '{OP_APPEND, 32'h8000_0000, 1'b0, '{1'b0, 10'd0}},
    '{OP_APPEND, 32'hFFFF_FFFF, 1'b0, '{1'b0, 10'd0}},
    '{OP_APPEND, 32'h0000_0000, 1'b0, '{1'b0, 10'd0}},
    '{OP_APPEND, 32'h0000_0005, 1'b0, '{1'b0, 10'd0}},
    '{OP_APPEND, 32'h7FFF_FFFF, 1'b0, '{1'b0, 10'd0}},
    '{OP_SEARCH, 32'h8000_0000, 1'b0, '{1'b0, 10'd0}},
    '{OP_SEARCH, 32'h7FFF_FFFF, 1'b0, '{1'b0, 10'd0}},
    '{OP_SEARCH, 32'hFFFF_FFFF, 1'b0, '{1'b0, 10'd0}},
    '{OP_SEARCH, 32'h0000_0000, 1'b0, '{1'b0, 10'd0}},
    '{OP_SEARCH, 32'h0000_0003, 1'b0, '{1'b0, 10'd0}},  // absent key
    '{OP_CLEAR,  32'hA5A5_A5A5, 1'b0, '{1'b0, 10'd0}},
    '{OP_SEARCH, 32'h0000_0005, 1'b1, '{1'b0, 10'd0}},  // cleared table misses
    '{OP_APPEND, 32'h0000_0009, 1'b0, '{1'b0, 10'd0}},
    '{OP_APPEND, 32'h0000_0009, 1'b0, '{1'b0, 10'd0}},
    '{OP_APPEND, 32'h0000_0009, 1'b0, '{1'b0, 10'd0}},
    '{OP_APPEND, 32'h0000_0009, 1'b0, '{1'b0, 10'd0}},
    '{OP_SEARCH, 32'h0000_0009, 1'b0, '{1'b0, 10'd0}},  // duplicates: first probe hit
    '{OP_APPEND, 32'h0000_0002, 1'b0, '{1'b0, 10'd0}},  // table now out of order
    '{OP_SEARCH, 32'h0000_0002, 1'b0, '{1'b0, 10'd0}},
    '{OP_SEARCH, 32'h0000_0009, 1'b0, '{1'b0, 10'd0}},
    '{OP_UNUSED, 32'h0000_0000, 1'b0, '{1'b0, 10'd0}},
    '{OP_SEARCH, 32'h7FFF_FFFF, 1'b0, '{1'b0, 10'd0}}
  };

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     in_valid_i  = 1'b0;
  logic                     in_stall_o;
  logic [OPC_W-1:0]         in_opcode_i = '0;
  logic signed [DATA_W-1:0] in_value_i  = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic                     out_found_o;
  logic [IDX_W-1:0]         out_match_index_o;

  int unsigned    tx_idle_pct = 10;
  int unsigned    rx_idle_pct = 78;
  bit             rx_hold_req = 1'b0;
  int unsigned    fail_count  = 0;
  search_result_t search_results_q [$];
  search_result_t head_result;

  // Shadow copy of the table and its fill level.
  logic signed [DATA_W-1:0] model_table [TABLE_DEPTH];
  int unsigned              model_count = 0;

  sorted_table_binary_search_top u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .in_opcode_i       (in_opcode_i),
    .in_value_i        (in_value_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_found_o       (out_found_o),
    .out_match_index_o (out_match_index_o)
  );

  always #2 clk_i = ~clk_i;

  // Halve the bounds over the shadow table until a hit or until they cross.
  function automatic search_result_t binary_lookup(input logic signed [DATA_W-1:0] key);
    int             lo;
    int             hi;
    int             mid;
    search_result_t res;
    res = '0;
    lo  = 0;
    hi  = int'(model_count) - 1;
    while (lo <= hi && !res.found) begin
      mid = (lo + hi) / 2;
      if (model_table[mid] > key) begin
        hi = mid - 1;
      end else if (model_table[mid] < key) begin
        lo = mid + 1;
      end else begin
        res.found = 1'b1;
        res.index = mid[IDX_W-1:0];
      end
    end
    return res;
  endfunction

  function automatic void flag_mismatch(input string what, input int unsigned exp_v,
                                        input int unsigned act_v);
    fail_count++;
    $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, exp_v, act_v);
  endfunction

  // Offer one word, hold it until taken, then advance the shadow table.
  task automatic offer_word(input logic [OPC_W-1:0] op, input logic [DATA_W-1:0] value,
                            input logic use_typed = 1'b0, input search_result_t typed_res = '0);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    in_opcode_i <= op;
    in_value_i  <= value;
    do @(posedge clk_i); while (in_stall_o);
    case (op)
      OP_CLEAR: model_count = 0;
      OP_APPEND: begin
        if (model_count < TABLE_DEPTH) begin
          model_table[model_count] = value;
          model_count++;
        end
      end
      OP_SEARCH: search_results_q.push_back(use_typed ? typed_res : binary_lookup(value));
      default: ;
    endcase
  endtask

  // Check each accepted result word against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (search_results_q.size() == 0) begin
        fail_count++;
        $display("%0t ns: unexpected result word, expected none, actual found %0b index %0d",
                 $time, out_found_o, out_match_index_o);
      end else begin
        head_result = search_results_q.pop_front();
        if (out_found_o !== head_result.found) begin
          flag_mismatch("found", head_result.found, out_found_o);
        end
        if (out_match_index_o !== head_result.index) begin
          flag_mismatch("match_index", head_result.index, out_match_index_o);
        end
      end
    end
  end

  // Receiver: random stall, or a long hold-off when one is requested.
  initial begin
    int unsigned hold_left;
    forever begin
      @(posedge clk_i);
      if (rx_hold_req) begin
        hold_left = HOLD_CYCLES;
        while (hold_left != 0) begin
          out_stall_i <= 1'b1;
          @(posedge clk_i);
          hold_left--;
        end
        rx_hold_req = 1'b0;
      end
      out_stall_i <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // Stimulus and end of run.
  initial begin
    int unsigned       words_sent;
    int unsigned       set_len;
    int unsigned       pick;
    int unsigned       choice;
    int                set_vals [$];
    logic [DATA_W-1:0] key;
    bit                full_done;
    words_sent = 0;
    full_done  = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (DIRECTED_ROWS[i]) begin
      offer_word(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].value, DIRECTED_ROWS[i].use_typed,
                 DIRECTED_ROWS[i].result);
    end

    while (words_sent < RANDOM_WORDS) begin
      // Sender idles lightly first, then the receiver does, then neither.
      if (words_sent < RANDOM_WORDS / 3) begin
        tx_idle_pct = 10;
        rx_idle_pct = 78;
      end else if (words_sent < 2 * RANDOM_WORDS / 3) begin
        tx_idle_pct = 78;
        rx_idle_pct = 10;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end

      // Once: back up the output until the input stalls, drain, then fill the table to the top.
      if (tx_idle_pct == 0 && !full_done) begin
        full_done   = 1'b1;
        rx_hold_req = 1'b1;
        repeat (10) offer_word(OP_SEARCH, $urandom());
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (search_results_q.size() != 0) @(posedge clk_i);
        offer_word(OP_CLEAR, $urandom());
        set_vals.delete();
        repeat (TABLE_DEPTH) set_vals.push_back($urandom());
        set_vals.sort();
        foreach (set_vals[i]) offer_word(OP_APPEND, set_vals[i]);
        // appends to a full table are dropped
        repeat (3) offer_word(OP_APPEND, $urandom());
        offer_word(OP_SEARCH, set_vals[0]);
        offer_word(OP_SEARCH, set_vals[TABLE_DEPTH-1]);
        repeat (6) offer_word(OP_SEARCH, set_vals[$urandom_range(TABLE_DEPTH - 1)]);
        offer_word(OP_SEARCH, $urandom());
        // count the words of the fill above, one more than were sent
        words_sent += TABLE_DEPTH + 24;
      end

      choice = $urandom_range(99);
      if (choice < 8) begin
        // Noise: any code, the unused one too, against whatever the table holds.
        repeat ($urandom_range(1, 6)) begin
          pick = $urandom_range(3);
          offer_word(pick[1:0], $urandom());
          if (pick[1:0] != OP_UNUSED) words_sent++;
        end
      end else begin
        // Mostly a fresh table; sometimes append onto the old one.
        if (choice >= 15) begin
          offer_word(OP_CLEAR, $urandom());
          words_sent++;
        end
        set_len = ($urandom_range(9) == 0) ? $urandom_range(200) : $urandom_range(16);
        pick    = $urandom_range(2);
        set_vals.delete();
        repeat (set_len) begin
          case (pick)
            0: set_vals.push_back($urandom());
            1: set_vals.push_back(int'($urandom_range(15)) - 8);
            default: set_vals.push_back($urandom_range(1) ? 32'h7FFF_FFF0 + $urandom_range(15)
                                                          : 32'h8000_0000 + $urandom_range(15));
          endcase
        end
        // leave one set in ten unsorted
        if ($urandom_range(9) != 0) set_vals.sort();
        foreach (set_vals[i]) begin
          offer_word(OP_APPEND, set_vals[i]);
          words_sent++;
        end
        // Keys: mostly stored entries, some neighbors, some anything.
        repeat ($urandom_range(1, 8)) begin
          pick = $urandom_range(99);
          if (model_count != 0 && pick < 70) begin
            key = model_table[$urandom_range(model_count - 1)];
          end else if (model_count != 0 && pick < 85) begin
            key = model_table[$urandom_range(model_count - 1)]
                  + ($urandom_range(1) ? 32'h0000_0001 : 32'hFFFF_FFFF);
          end else begin
            key = $urandom();
          end
          offer_word(OP_SEARCH, key);
          words_sent++;
        end
      end

      // Now and then hold the sender until every result is back.
      if ($urandom_range(19) == 0) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (search_results_q.size() != 0) @(posedge clk_i);
      end
    end

    in_valid_i <= 1'b0;
    while (search_results_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #4_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

>>> files.f
+incdir+hdl
hdl/stbs_pkg.sv
hdl/stbs_ctrl.sv
hdl/stbs_dpath.sv
hdl/sorted_table_binary_search_top.sv
bench/tb_sorted_table_binary_search_top.sv
